// ===== hw/rtl/thsc_pkg.sv =====
// thsc_pkg: shared types and constants for the timed heater soak controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package thsc_pkg;

	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_CMD    = 2'd2;

	localparam logic [2:0] CMD_SET_TARGET = 3'd0;
	localparam logic [2:0] CMD_SET_DUR    = 3'd1;
	localparam logic [2:0] CMD_STOP       = 3'd2;
	localparam logic [2:0] CMD_PAUSE      = 3'd3;
	localparam logic [2:0] CMD_CONTINUE   = 3'd4;

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_RUNNING  = 2'd1;
	localparam logic [1:0] ST_PAUSED   = 2'd2;
	localparam logic [1:0] ST_FINISHED = 2'd3;

	localparam int          FULL_SCALE_C = 500;
	localparam logic [15:0] SEC_PER_MIN  = 16'd60;
	localparam logic [15:0] STOP_SECONDS = 16'd100;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] cmd_code;
		logic [9:0] cmd_value;
	} thsc_in_t;

	typedef struct packed {
		logic        fan_on;
		logic        countdown_running;
		logic [15:0] seconds_left;
		logic [8:0]  temperature_c;
		logic [1:0]  run_status;
		logic        finished_now;
	} thsc_status_t;

endpackage

// ===== hw/rtl/timed_heater_soak_controller.sv =====
// timed_heater_soak_controller: heater/fan soak controller, stream in, stream out.
// Path: the input register captures the word at accept; the result register takes the update when the output is free.
// Throughput: one word per cycle while the output is taken; the controller state updates in one pass.
// Reset: arst_n asynchronous active low; target 0, soak 100 s, all flags clear.
// Depends on thsc_pkg, thsc_in_stage, thsc_ctrl, thsc_out_stage.
`timescale 1ns / 1ps

module timed_heater_soak_controller import thsc_pkg::*; #(
	parameter int ADC_BITS  = 12,
	parameter int DUTY_BITS = 8,
	localparam int IN_W  = ((ADC_BITS + 13 + 7) / 8) * 8,
	localparam int OUT_W = ((DUTY_BITS + 29 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // sensor_sample, cmd_code[3], cmd_value[10]
	input  logic [1:0]       s_tuser,  // req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // heater_duty, fan_on, countdown_running,
	                                   // seconds_left[16], temperature_c[9], run_status[2]
	output logic             m_tlast   // finished_now
);

	logic                  valid_s1;
	logic                  advance;
	logic                  load;
	thsc_in_t              in_word;
	thsc_in_t              word_s1;
	logic [ADC_BITS+8:0]   t_fx_s1;
	logic [DUTY_BITS-1:0]  duty_next, duty_q;
	thsc_status_t          status_next, status_q;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign load     = s_tvalid && s_tready;

	assign in_word.req_type  = s_tuser;
	assign in_word.cmd_code  = s_tdata[ADC_BITS+2:ADC_BITS];
	assign in_word.cmd_value = s_tdata[ADC_BITS+12:ADC_BITS+3];

	thsc_in_stage #(.ADC_BITS(ADC_BITS)) u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.advance       (advance),
		.in_word       (in_word),
		.sensor_sample (s_tdata[ADC_BITS-1:0]),
		.valid_s1      (valid_s1),
		.word_s1       (word_s1),
		.t_fx_s1       (t_fx_s1)
	);

	thsc_ctrl #(.ADC_BITS(ADC_BITS), .DUTY_BITS(DUTY_BITS)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.word_s1     (word_s1),
		.t_fx_s1     (t_fx_s1),
		.duty_next   (duty_next),
		.status_next (status_next)
	);

	thsc_out_stage #(.DUTY_BITS(DUTY_BITS)) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.duty_next   (duty_next),
		.status_next (status_next),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.duty_q      (duty_q),
		.status_q    (status_q)
	);

	assign m_tdata = OUT_W'({status_q.run_status, status_q.temperature_c,
		status_q.seconds_left, status_q.countdown_running, status_q.fan_on, duty_q});
	assign m_tlast = status_q.finished_now;

`ifndef SYNTHESIS
	a_fin_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> status_q.run_status == ST_FINISHED)
		else $error("finish word without finished status");

	a_fin_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> status_q.seconds_left == 16'd0 && duty_q == '0
			&& !status_q.fan_on && !status_q.countdown_running)
		else $error("finish word with heater, fan or count still active");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output free");
`endif

endmodule

// ===== hw/rtl/thsc_in_stage.sv =====
// thsc_in_stage: input register; scales the ADC reading to fixed-point degrees.
// Depends on thsc_pkg.
`timescale 1ns / 1ps

module thsc_in_stage import thsc_pkg::*; #(
	parameter int ADC_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  advance,
	input  thsc_in_t              in_word,
	input  logic [ADC_BITS-1:0]   sensor_sample,
	output logic                  valid_s1,
	output thsc_in_t              word_s1,
	output logic [ADC_BITS+8:0]   t_fx_s1
);

	localparam int TW = ADC_BITS + 9;

	logic [TW-1:0] t_fx;

	assign t_fx = TW'(sensor_sample) * TW'(FULL_SCALE_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s1 <= in_word;
			t_fx_s1 <= t_fx;
		end
	end

endmodule

// ===== hw/rtl/thsc_ctrl.sv =====
// thsc_ctrl: controller state and the single-pass update for one word.
// Depends on thsc_pkg.
`timescale 1ns / 1ps

module thsc_ctrl import thsc_pkg::*; #(
	parameter int ADC_BITS  = 12,
	parameter int DUTY_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  thsc_in_t              word_s1,
	input  logic [ADC_BITS+8:0]   t_fx_s1,
	output logic [DUTY_BITS-1:0]  duty_next,
	output thsc_status_t          status_next
);

	localparam int DW = ADC_BITS + 11;
	localparam int PW = ADC_BITS + 20;
	localparam logic signed [DW-1:0] ONE_FX = DW'(1) << ADC_BITS;
	localparam logic signed [DW-1:0] TWO_FX = DW'(2) << ADC_BITS;
	localparam logic [18:0] DUTY_MAX = 19'((1 << DUTY_BITS) - 1);

	logic [9:0]           target_q, target_n;
	logic [15:0]          soak_q, soak_n;
	logic                 fin_q, fin_n;
	logic                 run_q, run_n;
	logic                 pause_q, pause_n;
	logic                 timer_q, timer_n;
	logic                 fan_q, fan_n;
	logic [DUTY_BITS-1:0] duty_q, duty_n;
	logic [8:0]           temp_q, temp_n;
	logic                 fin_now;

	logic signed [DW-1:0] diff;
	logic [PW-1:0]        prod;
	logic [18:0]          p;

	assign diff = $signed({1'b0, target_q, ADC_BITS'(0)} - DW'(t_fx_s1));
	assign prod = PW'(diff[DW-2:0]) * PW'(target_q);
	assign p    = prod[PW-1:ADC_BITS+1];

	always_comb begin
		target_n = target_q;
		soak_n   = soak_q;
		fin_n    = fin_q;
		run_n    = run_q;
		pause_n  = pause_q;
		timer_n  = timer_q;
		fan_n    = fan_q;
		duty_n   = duty_q;
		temp_n   = temp_q;
		fin_now  = 1'b0;
		case (word_s1.req_type)
			REQ_SAMPLE: begin
				temp_n = t_fx_s1[ADC_BITS+8:ADC_BITS];
				if (run_q && soak_q != 16'd0) begin
					if (!timer_q && diff <= ONE_FX) timer_n = 1'b1;
					fan_n = 1'b1;
					if (diff < TWO_FX) duty_n = '0;
					else if (p > DUTY_MAX) duty_n = DUTY_MAX[DUTY_BITS-1:0];
					else duty_n = p[DUTY_BITS-1:0];
				end else if (soak_q <= 16'd1 && !fin_q) begin
					run_n   = 1'b0;
					fan_n   = 1'b0;
					timer_n = 1'b0;
					duty_n  = '0;
					fin_n   = 1'b1;
					soak_n  = 16'd0;
					fin_now = 1'b1;
				end else begin
					duty_n = '0;
					fan_n  = 1'b0;
				end
			end
			REQ_TICK: begin
				if (timer_q && soak_q != 16'd0) soak_n = soak_q - 16'd1;
			end
			REQ_CMD: begin
				run_n = 1'b1;
				unique case (word_s1.cmd_code)
					CMD_SET_TARGET: target_n = word_s1.cmd_value;
					CMD_SET_DUR: begin
						soak_n = 16'(word_s1.cmd_value) * SEC_PER_MIN;
						fin_n  = 1'b0;
					end
					CMD_STOP: begin
						run_n   = 1'b0;
						fan_n   = 1'b0;
						pause_n = 1'b0;
						timer_n = 1'b0;
						soak_n  = STOP_SECONDS;
						fin_n   = 1'b0;
						temp_n  = 9'd0;
					end
					CMD_PAUSE: begin
						pause_n = 1'b1;
						run_n   = 1'b0;
						fan_n   = 1'b0;
						timer_n = 1'b0;
					end
					CMD_CONTINUE: begin
						pause_n = 1'b0;
						run_n   = 1'b1;
						fan_n   = 1'b1;
						timer_n = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		duty_next                     = duty_n;
		status_next.fan_on            = fan_n;
		status_next.countdown_running = timer_n;
		status_next.seconds_left      = soak_n;
		status_next.temperature_c     = temp_n;
		status_next.finished_now      = fin_now;
		if (fin_n) status_next.run_status = ST_FINISHED;
		else if (run_n) status_next.run_status = ST_RUNNING;
		else if (pause_n) status_next.run_status = ST_PAUSED;
		else status_next.run_status = ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 10'd0;
			soak_q   <= STOP_SECONDS;
			fin_q    <= 1'b0;
			run_q    <= 1'b0;
			pause_q  <= 1'b0;
			timer_q  <= 1'b0;
			fan_q    <= 1'b0;
			duty_q   <= '0;
			temp_q   <= 9'd0;
		end else if (advance) begin
			target_q <= target_n;
			soak_q   <= soak_n;
			fin_q    <= fin_n;
			run_q    <= run_n;
			pause_q  <= pause_n;
			timer_q  <= timer_n;
			fan_q    <= fan_n;
			duty_q   <= duty_n;
			temp_q   <= temp_n;
		end
	end

endmodule

// ===== hw/rtl/thsc_out_stage.sv =====
// thsc_out_stage: result register holding the output word until taken.
// Depends on thsc_pkg.
`timescale 1ns / 1ps

module thsc_out_stage import thsc_pkg::*; #(
	parameter int DUTY_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [DUTY_BITS-1:0]  duty_next,
	input  thsc_status_t          status_next,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [DUTY_BITS-1:0]  duty_q,
	output thsc_status_t          status_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_q   <= duty_next;
			status_q <= status_next;
		end
	end

endmodule
